>>> design/quaternion_vector_rotate_unit_macros.svh
// Assertion macros for the quaternion vector rotate unit checker.
// Expects signals named clk and arst_n in the scope of use.
`ifndef QUATERNION_VECTOR_ROTATE_UNIT_MACROS_SVH
`define QUATERNION_VECTOR_ROTATE_UNIT_MACROS_SVH

// Concurrent assertion on the rising clock, off while reset is asserted
`define QVR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Cause in this cycle, consequence in the next one
`define QVR_ASSERT_NEXT(label, cause, effect, msg) \
	`QVR_ASSERT(label, (cause) |=> (effect), msg)

`endif

>>> design/qvr_pkg.sv
// Shared constants of the quaternion vector rotate unit.
// No dependencies; used by the config block, the top level and the checker.
package qvr_pkg;

	// Config write channel
	localparam int CFG_INDEX_WIDTH = 8;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUAT_W = 8'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUAT_X = 8'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUAT_Y = 8'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUAT_Z = 8'd3;

	// Register stages from input accept to output register
	localparam int PIPE_DEPTH = 6;

endpackage

>>> design/qvr_cfg_regs.sv
// Quaternion configuration registers with reset to the identity rotation.
// Depends on qvr_pkg for the register indexes.
module qvr_cfg_regs #(
	parameter int QUAT_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [qvr_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [QUAT_WIDTH-1:0]                cfg_data,
	output logic [3:0][QUAT_WIDTH-1:0]           quat
);

	// 1.0 in Q2.(QUAT_WIDTH-2)
	localparam logic [QUAT_WIDTH-1:0] QUAT_ONE = {2'b01, {(QUAT_WIDTH-2){1'b0}}};

	logic [3:0][QUAT_WIDTH-1:0] quat_q;

	assign cfg_ready = 1'b1;
	assign quat      = quat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q[0] <= QUAT_ONE;
			quat_q[1] <= '0;
			quat_q[2] <= '0;
			quat_q[3] <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				qvr_pkg::REG_QUAT_W: quat_q[0] <= cfg_data;
				qvr_pkg::REG_QUAT_X: quat_q[1] <= cfg_data;
				qvr_pkg::REG_QUAT_Y: quat_q[2] <= cfg_data;
				qvr_pkg::REG_QUAT_Z: quat_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

>>> design/qvr_first_product.sv
// Stages 1 to 3: effective quaternion, then p = q * (0, v) as products and sums.
// No package dependencies.
module qvr_first_product #(
	parameter int VECTOR_WIDTH = 24,
	parameter int QUAT_WIDTH   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [3:0][QUAT_WIDTH-1:0]          quat,
	input  logic [2:0][VECTOR_WIDTH-1:0]        vec,
	input  logic                                inverse,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [3:0][QUAT_WIDTH:0]            eq,
	output logic [3:0][VECTOR_WIDTH+QUAT_WIDTH+2:0] psum
);

	localparam int EW  = QUAT_WIDTH + 1;
	localparam int P1W = VECTOR_WIDTH + EW;
	localparam int PW  = P1W + 2;

	logic                 v_s1, v_s2, v_s3;
	logic                 adv_s1, adv_s2, adv_s3;
	logic signed [EW-1:0] qext [4];
	logic [3:0][EW-1:0]   eq_c;

	logic [3:0][EW-1:0]           eq_s1, eq_s2, eq_s3;
	logic [2:0][VECTOR_WIDTH-1:0] vec_s1;
	logic signed [P1W-1:0]        prod_s2 [12];
	logic signed [PW-1:0]         ext [12];
	logic [3:0][PW-1:0]           psum_c, psum_s3;

	function automatic logic signed [P1W-1:0] mul(input logic [EW-1:0] a,
		input logic [VECTOR_WIDTH-1:0] b);
		logic signed [P1W-1:0] ae, be;
		ae = P1W'($signed(a));
		be = P1W'($signed(b));
		return ae * be;
	endfunction

	// Ready ripples back through any empty stage
	assign adv_s3    = !v_s3 || out_ready;
	assign adv_s2    = !v_s2 || adv_s3;
	assign adv_s1    = !v_s1 || adv_s2;
	assign in_ready  = adv_s1;
	assign out_valid = v_s3;
	assign eq        = eq_s3;
	assign psum      = psum_s3;

	// Conjugate the vector part for the inverse rotation; one extra bit
	// keeps the negated most negative value exact
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			qext[i] = EW'($signed(quat[i]));
			eq_c[i] = (inverse && i != 0) ? -qext[i] : qext[i];
		end
	end

	always_comb begin
		for (int k = 0; k < 12; k++) begin
			ext[k] = PW'(prod_s2[k]);
		end
		psum_c[0] = -ext[0] - ext[1] - ext[2];
		psum_c[1] =  ext[3] + ext[4] - ext[5];
		psum_c[2] =  ext[6] - ext[7] + ext[8];
		psum_c[3] =  ext[9] + ext[10] - ext[11];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			eq_s1  <= eq_c;
			vec_s1 <= vec;
		end
		if (adv_s2 && v_s1) begin
			eq_s2       <= eq_s1;
			prod_s2[0]  <= mul(eq_s1[1], vec_s1[0]);
			prod_s2[1]  <= mul(eq_s1[2], vec_s1[1]);
			prod_s2[2]  <= mul(eq_s1[3], vec_s1[2]);
			prod_s2[3]  <= mul(eq_s1[0], vec_s1[0]);
			prod_s2[4]  <= mul(eq_s1[2], vec_s1[2]);
			prod_s2[5]  <= mul(eq_s1[3], vec_s1[1]);
			prod_s2[6]  <= mul(eq_s1[0], vec_s1[1]);
			prod_s2[7]  <= mul(eq_s1[1], vec_s1[2]);
			prod_s2[8]  <= mul(eq_s1[3], vec_s1[0]);
			prod_s2[9]  <= mul(eq_s1[0], vec_s1[2]);
			prod_s2[10] <= mul(eq_s1[1], vec_s1[1]);
			prod_s2[11] <= mul(eq_s1[2], vec_s1[0]);
		end
		if (adv_s3 && v_s2) begin
			eq_s3   <= eq_s2;
			psum_s3 <= psum_c;
		end
	end

endmodule

>>> design/qvr_second_product.sv
// Stages 4 and 5: vector part of r = p * conj(q) as products and sums.
// No package dependencies.
module qvr_second_product #(
	parameter int VECTOR_WIDTH = 24,
	parameter int QUAT_WIDTH   = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [3:0][QUAT_WIDTH:0]                 eq,
	input  logic [3:0][VECTOR_WIDTH+QUAT_WIDTH+2:0]  psum,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [2:0][VECTOR_WIDTH+2*QUAT_WIDTH+5:0] rsum
);

	localparam int EW  = QUAT_WIDTH + 1;
	localparam int PW  = VECTOR_WIDTH + EW + 2;
	localparam int P2W = PW + EW;
	localparam int RW  = P2W + 2;

	logic                  v_s4, v_s5;
	logic                  adv_s4, adv_s5;
	logic signed [P2W-1:0] prod_s4 [12];
	logic signed [RW-1:0]  ext [12];
	logic [2:0][RW-1:0]    rsum_c, rsum_s5;

	function automatic logic signed [P2W-1:0] mul(input logic [PW-1:0] a,
		input logic [EW-1:0] b);
		logic signed [P2W-1:0] ae, be;
		ae = P2W'($signed(a));
		be = P2W'($signed(b));
		return ae * be;
	endfunction

	assign adv_s5    = !v_s5 || out_ready;
	assign adv_s4    = !v_s4 || adv_s5;
	assign in_ready  = adv_s4;
	assign out_valid = v_s5;
	assign rsum      = rsum_s5;

	// Signs fold in the conjugate's negated vector part
	always_comb begin
		for (int k = 0; k < 12; k++) begin
			ext[k] = RW'(prod_s4[k]);
		end
		rsum_c[0] = -ext[0] + ext[1] - ext[2]  + ext[3];
		rsum_c[1] = -ext[4] + ext[5] + ext[6]  - ext[7];
		rsum_c[2] = -ext[8] - ext[9] + ext[10] + ext[11];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv_s4) v_s4 <= in_valid;
			if (adv_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && in_valid) begin
			prod_s4[0]  <= mul(psum[0], eq[1]);
			prod_s4[1]  <= mul(psum[1], eq[0]);
			prod_s4[2]  <= mul(psum[2], eq[3]);
			prod_s4[3]  <= mul(psum[3], eq[2]);
			prod_s4[4]  <= mul(psum[0], eq[2]);
			prod_s4[5]  <= mul(psum[1], eq[3]);
			prod_s4[6]  <= mul(psum[2], eq[0]);
			prod_s4[7]  <= mul(psum[3], eq[1]);
			prod_s4[8]  <= mul(psum[0], eq[3]);
			prod_s4[9]  <= mul(psum[1], eq[2]);
			prod_s4[10] <= mul(psum[2], eq[1]);
			prod_s4[11] <= mul(psum[3], eq[0]);
		end
		if (adv_s5 && v_s4) begin
			rsum_s5 <= rsum_c;
		end
	end

endmodule

>>> design/qvr_round_sat.sv
// Stage 6: round half up, drop the fraction bits, saturate, output register.
// No package dependencies.
module qvr_round_sat #(
	parameter int VECTOR_WIDTH = 24,
	parameter int QUAT_WIDTH   = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic [2:0][VECTOR_WIDTH+2*QUAT_WIDTH+5:0] rsum,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [2:0][VECTOR_WIDTH-1:0]              rot,
	output logic                                      saturated
);

	localparam int RW = VECTOR_WIDTH + 2 * QUAT_WIDTH + 6;
	localparam int S  = 2 * (QUAT_WIDTH - 2);
	localparam int TW = RW + 1 - S;

	localparam logic [RW:0] HALF = {{(RW+1-S){1'b0}}, 1'b1, {(S-1){1'b0}}};
	localparam logic signed [TW-1:0] VMAX =
		{{(TW-VECTOR_WIDTH+1){1'b0}}, {(VECTOR_WIDTH-1){1'b1}}};
	localparam logic signed [TW-1:0] VMIN =
		{{(TW-VECTOR_WIDTH+1){1'b1}}, {(VECTOR_WIDTH-1){1'b0}}};

	logic                          v_s6, adv_s6;
	logic signed [RW:0]            rnd [3];
	logic signed [TW-1:0]          trunc [3];
	logic [2:0]                    over, under;
	logic [2:0][VECTOR_WIDTH-1:0]  rot_c, rot_s6;
	logic                          sat_s6;

	assign adv_s6    = !v_s6 || out_ready;
	assign in_ready  = adv_s6;
	assign out_valid = v_s6;
	assign rot       = rot_s6;
	assign saturated = sat_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i]   = $signed({rsum[i][RW-1], rsum[i]}) + $signed(HALF);
			trunc[i] = rnd[i][RW:S];
			over[i]  = trunc[i] > VMAX;
			under[i] = trunc[i] < VMIN;
			if (over[i]) begin
				rot_c[i] = VMAX[VECTOR_WIDTH-1:0];
			end else if (under[i]) begin
				rot_c[i] = VMIN[VECTOR_WIDTH-1:0];
			end else begin
				rot_c[i] = trunc[i][VECTOR_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv_s6) begin
			v_s6 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s6 && in_valid) begin
			rot_s6 <= rot_c;
			sat_s6 <= |(over | under);
		end
	end

endmodule

>>> design/quaternion_vector_rotate_unit.sv
// Quaternion vector rotate unit: top level tying config, product stages and rounding.
// Depends on qvr_pkg, qvr_cfg_regs, qvr_first_product, qvr_second_product, qvr_round_sat.
//
// Usage:
//   Write the rotation quaternion (w, x, y, z, signed Q2.14) over the cfg channel,
//   index 0..3; other indexes are dropped. The channel is always ready. Write only
//   while no request is in flight. Reset loads the identity rotation (w = 1.0).
//   Send vectors on s_axis: tdata holds vec_x, vec_y, vec_z, tuser[0] selects the
//   inverse rotation (conjugate quaternion). Results leave on m_axis: tdata holds
//   rot_x, rot_y, rot_z, tuser[0] flags that a component clipped to range.
//   The quaternion is not normalized, so results scale by |q|^2.
//
// Timing:
//   Six register stages, s1 to s6: a request accepted on s_axis passes through them
//   in order and shows valid on m_axis from s6. One request enters per cycle while
//   s_axis_tready is high, so throughput is one per clock; the two sets of twelve
//   multipliers each have their own stage. When m_axis stalls, the output stage holds,
//   empty stages behind it keep filling, and s_axis_tready drops only once all six
//   stages hold a request. Reset empties the pipeline.
module quaternion_vector_rotate_unit #(
	parameter int VECTOR_WIDTH = 24,
	parameter int QUAT_WIDTH   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [qvr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [QUAT_WIDTH-1:0]               cfg_data,
	// input stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [((3*VECTOR_WIDTH+7)/8)*8-1:0] s_axis_tdata,  // vec_x, vec_y, vec_z, zero pad
	input  logic [0:0]                          s_axis_tuser,  // inverse
	// output stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [((3*VECTOR_WIDTH+7)/8)*8-1:0] m_axis_tdata,  // rot_x, rot_y, rot_z, zero pad
	output logic [0:0]                          m_axis_tuser   // saturated
);

	localparam int TDATA_WIDTH = ((3 * VECTOR_WIDTH + 7) / 8) * 8;
	localparam int EW          = QUAT_WIDTH + 1;
	localparam int PW          = VECTOR_WIDTH + EW + 2;
	localparam int RW          = VECTOR_WIDTH + 2 * QUAT_WIDTH + 6;

	logic [3:0][QUAT_WIDTH-1:0]   quat;
	logic [2:0][VECTOR_WIDTH-1:0] vec;
	logic [2:0][VECTOR_WIDTH-1:0] rot;
	logic                         saturated;

	// first product to second product
	logic               fp_valid, fp_ready;
	logic [3:0][EW-1:0] fp_eq;
	logic [3:0][PW-1:0] fp_psum;

	// second product to rounding
	logic               sp_valid, sp_ready;
	logic [2:0][RW-1:0] sp_rsum;

	// Unpack the vector; pad bits above the three fields are ignored
	assign vec[0] = s_axis_tdata[VECTOR_WIDTH-1:0];
	assign vec[1] = s_axis_tdata[2*VECTOR_WIDTH-1:VECTOR_WIDTH];
	assign vec[2] = s_axis_tdata[3*VECTOR_WIDTH-1:2*VECTOR_WIDTH];

	qvr_cfg_regs #(
		.QUAT_WIDTH(QUAT_WIDTH)
	) u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.quat     (quat)
	);

	// Stages 1-3: conjugate select, q * (0, v)
	qvr_first_product #(
		.VECTOR_WIDTH(VECTOR_WIDTH),
		.QUAT_WIDTH  (QUAT_WIDTH)
	) u_first_product (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.quat     (quat),
		.vec      (vec),
		.inverse  (s_axis_tuser[0]),
		.out_valid(fp_valid),
		.out_ready(fp_ready),
		.eq       (fp_eq),
		.psum     (fp_psum)
	);

	// Stages 4-5: p * conj(q), vector part only
	qvr_second_product #(
		.VECTOR_WIDTH(VECTOR_WIDTH),
		.QUAT_WIDTH  (QUAT_WIDTH)
	) u_second_product (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fp_valid),
		.in_ready (fp_ready),
		.eq       (fp_eq),
		.psum     (fp_psum),
		.out_valid(sp_valid),
		.out_ready(sp_ready),
		.rsum     (sp_rsum)
	);

	// Stage 6: round, saturate, hold for the receiver
	qvr_round_sat #(
		.VECTOR_WIDTH(VECTOR_WIDTH),
		.QUAT_WIDTH  (QUAT_WIDTH)
	) u_round_sat (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sp_valid),
		.in_ready (sp_ready),
		.rsum     (sp_rsum),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.rot      (rot),
		.saturated(saturated)
	);

	// Pack the result; pad bits read zero
	assign m_axis_tdata    = TDATA_WIDTH'({rot[2], rot[1], rot[0]});
	assign m_axis_tuser[0] = saturated;

endmodule

>>> design/qvr_port_checker.sv
// Port-level checker for the quaternion vector rotate unit, bound to the top level.
// Depends on qvr_pkg and quaternion_vector_rotate_unit_macros.svh.
`include "quaternion_vector_rotate_unit_macros.svh"

module qvr_port_checker #(
	parameter int VECTOR_WIDTH = 24
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [((3*VECTOR_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	input logic [0:0]                          m_axis_tuser
);

	localparam int CW = $clog2(qvr_pkg::PIPE_DEPTH + 1);
	localparam logic [VECTOR_WIDTH-1:0] VMAX = {1'b0, {(VECTOR_WIDTH-1){1'b1}}};
	localparam logic [VECTOR_WIDTH-1:0] VMIN = {1'b1, {(VECTOR_WIDTH-1){1'b0}}};

	logic [CW-1:0]           pending_q;
	logic                    in_acc, out_acc;
	logic [VECTOR_WIDTH-1:0] rot_x, rot_y, rot_z;
	logic                    at_bound;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign rot_x   = m_axis_tdata[VECTOR_WIDTH-1:0];
	assign rot_y   = m_axis_tdata[2*VECTOR_WIDTH-1:VECTOR_WIDTH];
	assign rot_z   = m_axis_tdata[3*VECTOR_WIDTH-1:2*VECTOR_WIDTH];
	assign at_bound = rot_x == VMAX || rot_x == VMIN || rot_y == VMAX ||
		rot_y == VMIN || rot_z == VMAX || rot_z == VMIN;

	// Count requests accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + CW'(in_acc) - CW'(out_acc);
		end
	end

	`QVR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
		"stalled result changed or dropped")
	`QVR_ASSERT(a_no_invented, m_axis_tvalid |-> pending_q != '0,
		"result shown with no request in flight")
	`QVR_ASSERT(a_depth, pending_q <= CW'(qvr_pkg::PIPE_DEPTH),
		"more requests in flight than pipeline stages")
	`QVR_ASSERT(a_sat_bound, m_axis_tvalid && m_axis_tuser[0] |-> at_bound,
		"saturated flag set with no component at a bound")

endmodule

bind quaternion_vector_rotate_unit qvr_port_checker #(
	.VECTOR_WIDTH(VECTOR_WIDTH)
) u_qvr_port_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);
